### rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// shared constants, controller states and the control/status structs of the
// table linear interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = AddrW + 1;
  localparam int DataW      = 32;
  localparam int EntryW     = 2 * DataW;
  localparam int ProdW      = 2 * DataW;
  localparam int QuoCap     = 40;
  localparam int QuoW       = QuoCap + 1;
  localparam int ResW       = QuoW + 1;
  localparam int DivCntW    = $clog2(QuoCap);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_RD_FIRST = 12'b0000_0000_0010,
    ST_RD_LAST  = 12'b0000_0000_0100,
    ST_SRCH_RD  = 12'b0000_0000_1000,
    ST_SRCH_CMP = 12'b0000_0001_0000,
    ST_RD_K0    = 12'b0000_0010_0000,
    ST_RD_K1    = 12'b0000_0100_0000,
    ST_CALC     = 12'b0000_1000_0000,
    ST_MUL      = 12'b0001_0000_0000,
    ST_DIV_CHK  = 12'b0010_0000_0000,
    ST_DIV      = 12'b0100_0000_0000,
    ST_FIN      = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID,
    ADDR_KM1,
    ADDR_K
  } addr_sel_e;

  typedef struct packed {
    logic      wr;
    logic      ld_query;
    logic      set_err;
    logic      ld_first;
    logic      ld_last_val;
    logic      srch_init;
    logic      srch_step;
    logic      ld_k0;
    logic      ld_k1;
    logic      calc;
    logic      mul;
    logic      div_init;
    logic      div_step;
    logic      emit;
    addr_sel_e addr_sel;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic out_span;
    logic hit_first;
    logic hit_last;
    logic cnt_zero;
    logic dt_zero;
    logic big;
    logic div_last;
  } sts_t;

endpackage

### rtl/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tli_datapath.sv
// ----------------------------------------------------------------------------
// tli_datapath
// table memory, search registers, multiplier, serial divider and result
// register of the interpolator
// ----------------------------------------------------------------------------
module tli_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tli_pkg::cmd_t               cmd_i,
  output tli_pkg::sts_t               sts_o,
  input  logic                        cfg_we_i,
  input  logic [tli_pkg::CntW-1:0]    cfg_data_i,
  input  logic [tli_pkg::AddrW-1:0]   entry_index_i,
  input  logic signed [31:0]          entry_time_i,
  input  logic signed [31:0]          entry_value_i,
  input  logic signed [31:0]          query_time_i,
  output logic signed [31:0]          result_value_o,
  output logic                        out_of_range_o
);
  import tli_pkg::*;

  logic [CntW-1:0]            points_q, n;
  logic [EntryW-1:0]          rdata;
  logic signed [DataW-1:0]    rd_t, rd_v;
  logic [AddrW-1:0]           raddr;
  logic signed [DataW-1:0]    t_q, t0_q, v0_q, t1_q, v1_q;
  logic [CntW-1:0]            lo_q, cnt_q, half, mid, k, n_m1;
  logic                       err_q, neg_q;
  logic [DataW-1:0]           ma_q, mb_q, md_q;
  logic [ProdW-1:0]           p_q;
  logic [DataW-1:0]           rem_q;
  logic [QuoW-1:0]            quo_q;
  logic [DivCntW-1:0]         dcnt_q;
  logic signed [DataW:0]      dt, dv, dtq;
  logic [DataW:0]             r2;
  logic signed [ResW-1:0]     res;
  logic signed [DataW-1:0]    res_sat;

  assign n    = (points_q > CntW'(TableDepth)) ? CntW'(TableDepth) : points_q;
  assign n_m1 = n - CntW'(1);
  assign rd_t = rdata[EntryW-1:DataW];
  assign rd_v = rdata[DataW-1:0];
  assign half = cnt_q >> 1;
  assign mid  = lo_q + half;
  assign k    = (lo_q == '0) ? CntW'(1) : ((lo_q > n_m1) ? n_m1 : lo_q);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_ZERO: raddr = '0;
      ADDR_LAST: raddr = n_m1[AddrW-1:0];
      ADDR_MID:  raddr = mid[AddrW-1:0];
      ADDR_KM1:  raddr = k[AddrW-1:0] - AddrW'(1);
      ADDR_K:    raddr = k[AddrW-1:0];
      default:   raddr = '0;
    endcase
  end

  tli_ram #(
    .Width(EntryW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (entry_index_i),
    .wdata_i ({entry_time_i, entry_value_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign dt  = {t1_q[DataW-1], t1_q} - {t0_q[DataW-1], t0_q};
  assign dv  = {v1_q[DataW-1], v1_q} - {v0_q[DataW-1], v0_q};
  assign dtq = {t_q[DataW-1], t_q} - {t0_q[DataW-1], t0_q};
  assign r2  = {rem_q, p_q[QuoCap-1]};

  assign sts_o.n_lt2     = n < CntW'(2);
  assign sts_o.out_span  = (t_q < t0_q) || (t_q > rd_t);
  assign sts_o.hit_first = t_q == t0_q;
  assign sts_o.hit_last  = t_q == rd_t;
  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.dt_zero   = dt == '0;
  assign sts_o.big       = {8'd0, p_q[ProdW-1:QuoCap]} >= md_q;
  assign sts_o.div_last  = dcnt_q == DivCntW'(QuoCap - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= '0;
    end else if (cfg_we_i) begin
      points_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_query) begin
      t_q   <= query_time_i;
      quo_q <= '0;
      neg_q <= 1'b0;
    end
    if (cmd_i.set_err) begin
      err_q <= 1'b1;
    end else if (cmd_i.ld_query) begin
      err_q <= 1'b0;
    end
    if (cmd_i.ld_first || cmd_i.ld_k0) begin
      t0_q <= rd_t;
      v0_q <= rd_v;
    end
    if (cmd_i.ld_last_val) begin
      v0_q <= rd_v;
    end
    if (cmd_i.ld_k1) begin
      t1_q <= rd_t;
      v1_q <= rd_v;
    end
    if (cmd_i.srch_init) begin
      lo_q  <= '0;
      cnt_q <= n;
    end else if (cmd_i.srch_step) begin
      if (rd_t < t_q) begin
        lo_q  <= mid + CntW'(1);
        cnt_q <= cnt_q - half - CntW'(1);
      end else begin
        cnt_q <= half;
      end
    end
    if (cmd_i.calc) begin
      md_q  <= dt[DataW] ? DataW'(-dt) : dt[DataW-1:0];
      ma_q  <= dv[DataW] ? DataW'(-dv) : dv[DataW-1:0];
      mb_q  <= dtq[DataW] ? DataW'(-dtq) : dtq[DataW-1:0];
      neg_q <= (dv[DataW] ^ dtq[DataW]) ^ dt[DataW];
    end
    if (cmd_i.mul) begin
      p_q <= ma_q * mb_q;
    end
    if (cmd_i.div_init) begin
      rem_q  <= DataW'(p_q[ProdW-1:QuoCap]);
      dcnt_q <= '0;
      if (sts_o.big) begin
        quo_q <= QuoW'(1) << QuoCap;
      end
    end else if (cmd_i.div_step) begin
      if (r2 >= {1'b0, md_q}) begin
        rem_q <= DataW'(r2 - {1'b0, md_q});
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= r2[DataW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
      p_q    <= p_q << 1;
      dcnt_q <= dcnt_q + DivCntW'(1);
    end
    if (cmd_i.emit) begin
      result_value_o <= err_q ? '0 : res_sat;
      out_of_range_o <= err_q;
    end
  end

  always_comb begin
    if (neg_q) begin
      res = ResW'(v0_q) - $signed({1'b0, quo_q});
    end else begin
      res = ResW'(v0_q) + $signed({1'b0, quo_q});
    end
    if (!res[ResW-1] && (res[ResW-2:DataW-1] != '0)) begin
      res_sat = 32'sh7fff_ffff;
    end else if (res[ResW-1] && (res[ResW-2:DataW-1] != '1)) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res[DataW-1:0];
    end
  end

endmodule

### rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// sequencer for loads and queries: table reads, binary search, multiply,
// serial divide and result hand-off
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          func_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tli_pkg::sts_t sts_i,
  output tli_pkg::cmd_t cmd_o
);
  import tli_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc, out_free;

  assign in_stall_o  = state_q != ST_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.addr_sel = ADDR_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && func_i == FUNC_LOAD) begin
          cmd_o.wr = 1'b1;
        end else if (in_acc) begin
          cmd_o.ld_query = 1'b1;
          if (sts_i.n_lt2) begin
            cmd_o.set_err = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_RD_FIRST;
          end
        end
      end
      ST_RD_FIRST: begin
        cmd_o.ld_first = 1'b1;
        cmd_o.addr_sel = ADDR_LAST;
        state_d = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        if (sts_i.out_span) begin
          cmd_o.set_err = 1'b1;
          state_d = ST_FIN;
        end else if (sts_i.hit_first) begin
          state_d = ST_FIN;
        end else if (sts_i.hit_last) begin
          cmd_o.ld_last_val = 1'b1;
          state_d = ST_FIN;
        end else begin
          cmd_o.srch_init = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.cnt_zero) begin
          cmd_o.addr_sel = ADDR_KM1;
          state_d = ST_RD_K0;
        end else begin
          cmd_o.addr_sel = ADDR_MID;
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd_o.srch_step = 1'b1;
        state_d = ST_SRCH_RD;
      end
      ST_RD_K0: begin
        cmd_o.ld_k0    = 1'b1;
        cmd_o.addr_sel = ADDR_K;
        state_d = ST_RD_K1;
      end
      ST_RD_K1: begin
        cmd_o.ld_k1 = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (sts_i.dt_zero) begin
          cmd_o.set_err = 1'b1;
          state_d = ST_FIN;
        end else begin
          cmd_o.calc = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        cmd_o.div_init = 1'b1;
        state_d = sts_i.big ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// piecewise linear interpolation over a table of Q16.16 time/value pairs
// ----------------------------------------------------------------------------
// input channel (in_valid_i / in_stall_o): func_i 0 writes one table entry
// from entry_index_i, entry_time_i, entry_value_i; func_i 1 queries at
// query_time_i. a load leaves the block idle and gives no output word.
// output channel (out_valid_o / out_stall_i): one word per query, held in an
// output register. config channel (cfg_valid_i / cfg_ready_o): writes
// points_in_use, always ready; write only while the block is idle.
// an interpolating query runs two end reads, a read and a compare per search
// probe, two segment reads, setup, multiply, overflow check and a 40-step
// divider; a capped quotient skips the divider, a zero-width segment ends after
// the segment reads, end hits and out-of-span queries after the end reads, and
// tables under two points go straight to the output stage.
// one query at a time: the next item is taken in the cycle after the word is
// loaded. a stalled output word holds, and a finished query waits for it.
// reset clears the point count and control state; table contents stay
// undefined until loaded.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [tli_pkg::AddrW-1:0] entry_index_i,
  input  logic signed [31:0]        entry_time_i,
  input  logic signed [31:0]        entry_value_i,
  input  logic signed [31:0]        query_time_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        result_value_o,
  output logic                      out_of_range_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tli_pkg::CntW-1:0]  points_in_use_i
);
  import tli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tli_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (points_in_use_i),
    .entry_index_i  (entry_index_i),
    .entry_time_i   (entry_time_i),
    .entry_value_i  (entry_value_i),
    .query_time_i   (query_time_i),
    .result_value_o (result_value_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_QUERY |=> in_stall_o)
    else $error("query did not occupy the block");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_LOAD |=> !in_stall_o)
    else $error("load occupied the block");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> result_value_o == '0)
    else $error("error word with nonzero value");

  a_new_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a query in flight");
`endif

endmodule
